[hdl/bhd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bhd_pkg
// shared types and constants of the bounded handle deque
// ----------------------------------------------------------------------------
package bhd_pkg;

    localparam int CMD_W          = 3;
    localparam int ST_W           = 2;
    localparam int CNT_W          = 7;
    localparam int DEPTH_DEF      = 64;
    localparam int HANDLE_W_DEF   = 16;
    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_FLUSH      = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // result of one step apart from the popped handle
    typedef struct packed {
        t_status          status;
        logic             pop;
        logic [CNT_W-1:0] count;
        logic             space;
        logic [CNT_W-1:0] removed;
    } t_meta;

endpackage : bhd_pkg
`default_nettype wire

[hdl/bhd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bhd_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module bhd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule : bhd_ram
`default_nettype wire

[hdl/bhd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bhd_ctrl
// front/back index and count bookkeeping, slot memory access per command
// ----------------------------------------------------------------------------
module bhd_ctrl
    import bhd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire logic [CNT_W-1:0] i_limit,
    output logic                  o_ram_en,
    output logic                  o_ram_we,
    output logic      [IDX_W-1:0] o_ram_addr,
    output t_meta                 o_meta
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back, n_back;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] front_prev, front_next, back_prev, back_next;
    logic             full, empty, access;
    t_cmd             cmd;

    assign cmd        = t_cmd'(i_command);
    assign full       = (r_count >= i_limit);
    assign empty      = (r_count == '0);
    assign front_prev = (r_front == '0) ? IDX_LAST : r_front - 1'b1;
    assign front_next = (r_front == IDX_LAST) ? '0 : r_front + 1'b1;
    assign back_prev  = (r_back == '0) ? IDX_LAST : r_back - 1'b1;
    assign back_next  = (r_back == IDX_LAST) ? '0 : r_back + 1'b1;

    always_comb begin
        n_front        = r_front;
        n_back         = r_back;
        n_count        = r_count;
        access         = 1'b0;
        o_ram_we       = 1'b0;
        o_ram_addr     = r_front;
        o_meta.status  = ST_DONE;
        o_meta.pop     = 1'b0;
        o_meta.removed = '0;
        unique case (cmd)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    n_front    = front_prev;
                    o_ram_addr = front_prev;
                    access     = 1'b1;
                    o_ram_we   = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    n_back     = back_next;
                    o_ram_addr = r_back;
                    access     = 1'b1;
                    o_ram_we   = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    n_front    = front_next;
                    o_ram_addr = r_front;
                    access     = 1'b1;
                    o_meta.pop = 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    n_back     = back_prev;
                    o_ram_addr = back_prev;
                    access     = 1'b1;
                    o_meta.pop = 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            CMD_FLUSH: begin
                o_meta.removed = r_count;
                n_count        = '0;
                n_front        = '0;
                n_back         = '0;
            end
            default: begin
            end
        endcase
        o_meta.count = n_count;
        o_meta.space = (n_count < i_limit);
        o_ram_en     = i_accept && access;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("entry count above storage depth");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == r_back))
        else $error("empty deque with front and back apart");

    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_command == CMD_FLUSH) |=>
            (r_count == '0 && r_front == '0 && r_back == '0))
        else $error("flush did not clear indices and count");

endmodule : bhd_ctrl
`default_nettype wire

[hdl/bounded_handle_deque.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_handle_deque
// double-ended queue of packet handles with a programmable capacity limit
// ----------------------------------------------------------------------------
// Takes one command per cycle: one transfer on the slave stream each clock
// while the master side keeps taking results, and gives exactly one result
// in the cycle after each command transfer. The handles live in a single-port
// slot memory with a registered read; each command touches at most
// one slot (write on push, read on pop), while indices and count live in
// flip-flops, so nothing overlaps on the memory port. The result register
// holds a stalled result together with the memory read data, and a new
// command is taken in the cycle that result leaves. The slot memory is not
// cleared after reset: a pop only ever reads a slot that a push wrote.
// max_entries is clamped to the smaller of DEPTH and 127; lowering it
// below the current count keeps the entries and only refuses pushes.
module bounded_handle_deque
    import bhd_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int HANDLE_WIDTH = HANDLE_W_DEF,
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int IN_BITS     = CMD_W + HANDLE_WIDTH,
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = ST_W + HANDLE_WIDTH + CNT_W + 1 + CNT_W,
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration write: max_entries
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    // command stream
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [IN_W-1:0]  i_s_tdata,  // command, handle_in
    // result stream
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic      [OUT_W-1:0] o_m_tdata   // status, handle_out, count_after,
                                              // space_left, removed_count
);

    // storage clamp of the programmed limit, count never exceeds this
    localparam logic [CNT_W-1:0] LIM_CAP =
        CNT_W'((DEPTH > (2**CNT_W - 1)) ? (2**CNT_W - 1) : DEPTH);

    logic [CNT_W-1:0]        r_max_entries;
    logic [CNT_W-1:0]        limit;
    logic                    in_accept;
    logic                    r_out_valid;
    t_meta                   meta, r_meta;
    logic                    ram_en, ram_we;
    logic [IDX_W-1:0]        ram_addr;
    logic [HANDLE_WIDTH-1:0] ram_rdata;
    logic [HANDLE_WIDTH-1:0] handle_out;
    logic [CMD_W-1:0]        command;
    logic [HANDLE_WIDTH-1:0] handle_in;

    // field unpacking, command in the low bits
    assign command   = i_s_tdata[CMD_W-1:0];
    assign handle_in = i_s_tdata[CMD_W +: HANDLE_WIDTH];

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
        end else if (i_cfg_valid) begin
            r_max_entries <= i_cfg_data;
        end
    end

    assign limit = (r_max_entries < LIM_CAP) ? r_max_entries : LIM_CAP;

    // a command transfer happens when the result register is free or draining
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_accept  = i_s_tvalid && o_s_tready;

    bhd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_command  (command),
        .i_limit    (limit),
        .o_ram_en   (ram_en),
        .o_ram_we   (ram_we),
        .o_ram_addr (ram_addr),
        .o_meta     (meta)
    );

    // slot memory, read data stays put while the result is stalled
    bhd_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (handle_in),
        .o_rdata (ram_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_meta <= meta;
        end
    end

    // popped handle comes straight from the memory read register
    assign handle_out = r_meta.pop ? ram_rdata : '0;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_meta.removed, r_meta.space, r_meta.count,
                                handle_out, r_meta.status});

endmodule : bounded_handle_deque
`default_nettype wire
